>>> hw/rtl/assert_macros.svh
// Assertion macros used by the sorted keyed record block top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SKRB_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to another in the next cycle.
`define SKRB_CHECK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/skrb_pkg.sv
// Types and constants of the sorted keyed record block
`timescale 1ns / 1ps
`default_nettype none
package skrb_pkg;

  localparam int KEY_W      = 17;
  localparam int SIZE_W     = 10;
  localparam int DATA_W     = 64;
  localparam int BS_W       = 13;
  localparam int CNT_OUT_W  = 7;
  localparam int HI_W       = 18;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 32;

  localparam logic [BS_W-1:0]   HEADER_BYTES   = 13'd12;
  localparam logic [BS_W-1:0]   BLOCK_SIZE_RST = 13'd512;
  localparam logic [CFG_AW-1:0] ADDR_BLOCK_SIZE = 2'd0;
  localparam logic signed [HI_W-1:0] HIGHEST_EMPTY = -18'sd1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUP       = 2'd1,
    ST_NO_ROOM   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_go;
    logic rem_go;
  } ctl_t;

  function automatic logic [BS_W-1:0] free_fn(input logic [BS_W-1:0] bsize,
                                              input logic [BS_W-1:0] used);
    logic [BS_W:0] total;
    logic [BS_W:0] bs_ext;
    total  = {1'b0, HEADER_BYTES} + {1'b0, used};
    bs_ext = {1'b0, bsize};
    return (total <= bs_ext) ? BS_W'(bs_ext - total) : '0;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sorted_keyed_record_block.sv
// Sorted keyed record block: top level with cell row, control and config port
//
// Usage:
//  - Input channel in_*: one item per handshake (in_valid high, in_stall low)
//    carrying op (insert, remove, find, clear), key, record data and size.
//  - Result channel out_*: exactly one result item per input item, in order,
//    with status, found payload, record count, free bytes and highest key.
//  - Config port cfg_*: APB-style, block_size at byte address 0, pready tied
//    high; write only while no item is in flight.
//  - The item is registered when taken, the result when its decide cycle ends.
//  - No new item is taken until the decide cycle of the last one is done. The
//    compare cycle compares the key against every cell of the row at once;
//    the decide cycle decides and shifts the row by one cell for insert or remove.
//  - When out_stall holds a result, a new item is still taken; its decide
//    cycle waits until the output register frees up.
//  - Reset empties the block (count and used bytes zero), sets block_size
//    to 512 and drops any pending result; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sorted_keyed_record_block
  import skrb_pkg::*;
#(
  parameter int MAX_RECORDS   = 64,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              in_op,
  input  wire logic [KEY_W-1:0]        in_key,
  input  wire logic [DATA_W-1:0]       in_record_data,
  input  wire logic [SIZE_W-1:0]       in_record_bytes,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [1:0]                   out_status,
  output logic [DATA_W-1:0]            out_found_data,
  output logic [CNT_OUT_W-1:0]         out_record_count,
  output logic [BS_W-1:0]              out_free_bytes,
  output logic signed [HI_W-1:0]       out_highest_key,
  input  wire logic                    cfg_psel,
  input  wire logic                    cfg_penable,
  input  wire logic                    cfg_pwrite,
  input  wire logic [CFG_AW-1:0]       cfg_paddr,
  input  wire logic [CFG_DW-1:0]       cfg_pwdata,
  output logic [CFG_DW-1:0]            cfg_prdata,
  output logic                         cfg_pready
);

  localparam int CW = $clog2(MAX_RECORDS + 1);

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

  state_t                     state_r;
  op_t                        op_r;
  logic [KEY_W-1:0]           key_r;
  logic [PAYLOAD_WIDTH-1:0]   data_r;
  logic [SIZE_W-1:0]          bytes_r;
  logic [CW-1:0]              count_r, count_nxt;
  logic [BS_W-1:0]            used_r, used_nxt;
  logic [BS_W-1:0]            block_size_r;
  logic                       out_valid_r;
  status_t                    status_r, status_nxt;
  logic [DATA_W-1:0]          found_r, found_nxt;
  logic [CW-1:0]              ocount_r;
  logic [BS_W-1:0]            free_r;
  logic signed [HI_W-1:0]     high_r, high_nxt;

  logic                       in_fire, out_fire, eval_fire, cfg_wr;
  logic                       ins_go, rem_go;
  ctl_t                       ctl;

  logic [KEY_W-1:0]           cell_key  [MAX_RECORDS];
  logic [SIZE_W-1:0]          cell_size [MAX_RECORDS];
  logic [PAYLOAD_WIDTH-1:0]   cell_pay  [MAX_RECORDS];
  logic [MAX_RECORDS-1:0]     match_vec, less_vec, occ_vec, last_oh, prev_oh;

  logic                       any_match, last_match, last_less, all_less;
  logic [PAYLOAD_WIDTH-1:0]   m_pay;
  logic [SIZE_W-1:0]          m_size;
  logic [KEY_W-1:0]           hi_old, hi_prev;
  logic [BS_W-1:0]            free_old;
  logic signed [HI_W-1:0]     hi_old_s;

  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign eval_fire = (state_r == S_EVAL) && (!out_valid_r || !out_stall);
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                     (cfg_paddr == ADDR_BLOCK_SIZE);

  assign ctl.cmp_en = in_fire;
  assign ctl.ins_go = ins_go;
  assign ctl.rem_go = rem_go;

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    logic                     l_less;
    logic [KEY_W-1:0]         l_key, r_key;
    logic [SIZE_W-1:0]        l_size, r_size;
    logic [PAYLOAD_WIDTH-1:0] l_pay, r_pay;

    assign occ_vec[i] = (CW'(i) < count_r);
    assign last_oh[i] = (count_r == CW'(i + 1));
    assign prev_oh[i] = (count_r == CW'(i + 2));

    if (i == 0) begin : g_first
      assign l_less = 1'b1;
      assign l_key  = '0;
      assign l_size = '0;
      assign l_pay  = '0;
    end else begin : g_mid_l
      assign l_less = less_vec[i-1];
      assign l_key  = cell_key[i-1];
      assign l_size = cell_size[i-1];
      assign l_pay  = cell_pay[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_last
      assign r_key  = '0;
      assign r_size = '0;
      assign r_pay  = '0;
    end else begin : g_mid_r
      assign r_key  = cell_key[i+1];
      assign r_size = cell_size[i+1];
      assign r_pay  = cell_pay[i+1];
    end

    skrb_cell #(
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ_vec[i]),
      .cmp_key   (in_key),
      .new_key   (key_r),
      .new_size  (bytes_r),
      .new_pay   (data_r),
      .left_less (l_less),
      .left_key  (l_key),
      .left_size (l_size),
      .left_pay  (l_pay),
      .right_key (r_key),
      .right_size(r_size),
      .right_pay (r_pay),
      .key       (cell_key[i]),
      .size      (cell_size[i]),
      .pay       (cell_pay[i]),
      .match     (match_vec[i]),
      .less      (less_vec[i])
    );
  end

  always_comb begin
    m_pay      = '0;
    m_size     = '0;
    hi_old     = '0;
    hi_prev    = '0;
    last_match = 1'b0;
    last_less  = 1'b0;
    for (int i = 0; i < MAX_RECORDS; i++) begin
      m_pay      = m_pay   | (cell_pay[i]  & {PAYLOAD_WIDTH{match_vec[i]}});
      m_size     = m_size  | (cell_size[i] & {SIZE_W{match_vec[i]}});
      hi_old     = hi_old  | (cell_key[i]  & {KEY_W{last_oh[i]}});
      hi_prev    = hi_prev | (cell_key[i]  & {KEY_W{prev_oh[i]}});
      last_match = last_match | (match_vec[i] & last_oh[i]);
      last_less  = last_less  | (less_vec[i]  & last_oh[i]);
    end
  end

  assign any_match = |match_vec;
  assign all_less  = (count_r == '0) || last_less;
  assign free_old  = free_fn(block_size_r, used_r);
  assign hi_old_s  = (count_r == '0) ? HIGHEST_EMPTY : $signed({1'b0, hi_old});

  always_comb begin
    ins_go     = 1'b0;
    rem_go     = 1'b0;
    status_nxt = ST_OK;
    found_nxt  = '0;
    count_nxt  = count_r;
    used_nxt   = used_r;
    high_nxt   = hi_old_s;
    case (op_r)
      OP_INSERT: begin
        if (any_match) begin
          status_nxt = ST_DUP;
        end else if ((count_r == CW'(MAX_RECORDS)) ||
                     ({{(BS_W-SIZE_W){1'b0}}, bytes_r} > free_old)) begin
          status_nxt = ST_NO_ROOM;
        end else begin
          ins_go    = eval_fire;
          count_nxt = count_r + CW'(1);
          used_nxt  = used_r + {{(BS_W-SIZE_W){1'b0}}, bytes_r};
          high_nxt  = all_less ? $signed({1'b0, key_r}) : hi_old_s;
        end
      end
      OP_REMOVE: begin
        if (!any_match) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          rem_go    = eval_fire;
          count_nxt = count_r - CW'(1);
          used_nxt  = used_r - {{(BS_W-SIZE_W){1'b0}}, m_size};
          if (count_r == CW'(1)) begin
            high_nxt = HIGHEST_EMPTY;
          end else if (last_match) begin
            high_nxt = $signed({1'b0, hi_prev});
          end else begin
            high_nxt = hi_old_s;
          end
        end
      end
      OP_FIND: begin
        if (!any_match) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          found_nxt = DATA_W'(m_pay);
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
        used_nxt  = '0;
        high_nxt  = HIGHEST_EMPTY;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      count_r      <= '0;
      used_r       <= '0;
      block_size_r <= BLOCK_SIZE_RST;
    end else begin
      if (cfg_wr) begin
        block_size_r <= cfg_pwdata[BS_W-1:0];
      end
      case (state_r)
        S_IDLE: begin
          if (out_fire) begin
            out_valid_r <= 1'b0;
          end
          if (in_fire) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (eval_fire) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            count_r     <= count_nxt;
            used_r      <= used_nxt;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= op_t'(in_op);
      key_r   <= in_key;
      data_r  <= in_record_data[PAYLOAD_WIDTH-1:0];
      bytes_r <= in_record_bytes;
    end
    if (eval_fire) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      ocount_r <= count_nxt;
      free_r   <= free_fn(block_size_r, used_nxt);
      high_r   <= high_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_found_data   = found_r;
  assign out_record_count = CNT_OUT_W'(ocount_r);
  assign out_free_bytes   = free_r;
  assign out_highest_key  = high_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_BLOCK_SIZE) ?
                      {{(CFG_DW-BS_W){1'b0}}, block_size_r} : '0;

  `SKRB_CHECK(a_count_bound, count_r <= CW'(MAX_RECORDS), "record count above capacity")
  `SKRB_CHECK(a_match_one, (state_r == S_EVAL) |-> $onehot0(match_vec), "key matched twice")
  `SKRB_CHECK(a_less_prefix, (state_r == S_EVAL) |-> (((less_vec >> 1) & ~less_vec) == '0), "row out of key order")
  `SKRB_CHECK(a_out_from_eval, $rose(out_valid_r) |-> $past(state_r == S_EVAL), "result without decide cycle")
  `SKRB_CHECK_NEXT(a_eval_done, eval_fire, (state_r == S_IDLE) && out_valid_r, "decide cycle did not post result")

endmodule
`default_nettype wire

>>> hw/rtl/skrb_cell.sv
// One record slot of the sorted row: compare, hold, load or shift
`timescale 1ns / 1ps
`default_nettype none
module skrb_cell
  import skrb_pkg::*;
#(
  parameter int PAYLOAD_WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire ctl_t                     ctl,
  input  wire logic                     occ,
  input  wire logic [KEY_W-1:0]         cmp_key,
  input  wire logic [KEY_W-1:0]         new_key,
  input  wire logic [SIZE_W-1:0]        new_size,
  input  wire logic [PAYLOAD_WIDTH-1:0] new_pay,
  input  wire logic                     left_less,
  input  wire logic [KEY_W-1:0]         left_key,
  input  wire logic [SIZE_W-1:0]        left_size,
  input  wire logic [PAYLOAD_WIDTH-1:0] left_pay,
  input  wire logic [KEY_W-1:0]         right_key,
  input  wire logic [SIZE_W-1:0]        right_size,
  input  wire logic [PAYLOAD_WIDTH-1:0] right_pay,
  output logic      [KEY_W-1:0]         key,
  output logic      [SIZE_W-1:0]        size,
  output logic      [PAYLOAD_WIDTH-1:0] pay,
  output logic                          match,
  output logic                          less
);

  logic [KEY_W-1:0]         key_r,   key_nxt;
  logic [SIZE_W-1:0]        size_r,  size_nxt;
  logic [PAYLOAD_WIDTH-1:0] pay_r,   pay_nxt;
  logic                     match_r, match_nxt;
  logic                     less_r,  less_nxt;

  always_comb begin
    key_nxt   = key_r;
    size_nxt  = size_r;
    pay_nxt   = pay_r;
    match_nxt = match_r;
    less_nxt  = less_r;
    if (ctl.cmp_en) begin
      match_nxt = occ && (key_r == cmp_key);
      less_nxt  = occ && (key_r < cmp_key);
    end
    if (ctl.ins_go && !less_r) begin
      if (left_less) begin
        key_nxt  = new_key;
        size_nxt = new_size;
        pay_nxt  = new_pay;
      end else begin
        key_nxt  = left_key;
        size_nxt = left_size;
        pay_nxt  = left_pay;
      end
    end else if (ctl.rem_go && !less_r) begin
      key_nxt  = right_key;
      size_nxt = right_size;
      pay_nxt  = right_pay;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    size_r  <= size_nxt;
    pay_r   <= pay_nxt;
    match_r <= match_nxt;
    less_r  <= less_nxt;
  end

  assign key   = key_r;
  assign size  = size_r;
  assign pay   = pay_r;
  assign match = match_r;
  assign less  = less_r;

endmodule
`default_nettype wire

>>> tb/sv/tb_sorted_keyed_record_block.sv
// Self-checking testbench for the sorted keyed record block with random stalls and config phases
`timescale 1ns / 1ps
module tb_sorted_keyed_record_block;
  import skrb_pkg::*;

  localparam int MAX_REC   = 64;
  localparam int LIMIT     = 500000;
  localparam int PRINT_CAP = 100;

  typedef struct {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic [SIZE_W-1:0] rec_bytes;
  } request_t;

  typedef struct packed {
    status_t                status;
    logic [DATA_W-1:0]      found;
    logic [CNT_OUT_W-1:0]   count;
    logic [BS_W-1:0]        free_bytes;
    logic signed [HI_W-1:0] high_key;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             in_op = OP_FIND;
  logic [KEY_W-1:0]       in_key = '0;
  logic [DATA_W-1:0]      in_record_data = '0;
  logic [SIZE_W-1:0]      in_record_bytes = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             out_status;
  logic [DATA_W-1:0]      out_found_data;
  logic [CNT_OUT_W-1:0]   out_record_count;
  logic [BS_W-1:0]        out_free_bytes;
  logic signed [HI_W-1:0] out_highest_key;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [CFG_DW-1:0]      cfg_pwdata = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  // Shadow of the block contents
  logic [KEY_W-1:0]  tbl_key [MAX_REC];
  logic [DATA_W-1:0] tbl_data[MAX_REC];
  logic [SIZE_W-1:0] tbl_size[MAX_REC];
  int                held = 0;
  logic [BS_W-1:0]   used_bytes = '0;
  logic [BS_W-1:0]   blk_size = BLOCK_SIZE_RST;

  request_t    pending_requests[$];
  result_t     expected_results[$];
  int unsigned requests_queued = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned send_wait = 0;
  int unsigned rcv_wait = 0;
  int unsigned long_hold = 0;
  int unsigned cycle_cnt = 0;
  logic        no_idle = 1'b0;

  sorted_keyed_record_block #(
    .MAX_RECORDS(MAX_REC),
    .PAYLOAD_WIDTH(DATA_W)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_key(in_key),
    .in_record_data(in_record_data),
    .in_record_bytes(in_record_bytes),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_found_data(out_found_data),
    .out_record_count(out_record_count),
    .out_free_bytes(out_free_bytes),
    .out_highest_key(out_highest_key),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
  endtask

  function automatic logic [BS_W-1:0] free_now();
    int total;
    total = int'(HEADER_BYTES) + int'(used_bytes);
    return (total <= int'(blk_size)) ? BS_W'(int'(blk_size) - total) : '0;
  endfunction

  function automatic int find_slot(input logic [KEY_W-1:0] k);
    for (int i = 0; i < held; i++)
      if (tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic result_t apply_request(input op_t op, input logic [KEY_W-1:0] k,
                                            input logic [DATA_W-1:0] d,
                                            input logic [SIZE_W-1:0] nb);
    result_t r;
    int slot;
    int pos;
    r = '0;
    r.status = ST_OK;
    slot = find_slot(k);
    case (op)
      OP_INSERT: begin
        if (slot >= 0) begin
          r.status = ST_DUP;
        end else if (held >= MAX_REC || nb > free_now()) begin
          r.status = ST_NO_ROOM;
        end else begin
          pos = 0;
          while (pos < held && tbl_key[pos] < k) pos++;
          for (int i = held; i > pos; i--) begin
            tbl_key[i]  = tbl_key[i-1];
            tbl_data[i] = tbl_data[i-1];
            tbl_size[i] = tbl_size[i-1];
          end
          tbl_key[pos]  = k;
          tbl_data[pos] = d;
          tbl_size[pos] = nb;
          held++;
          used_bytes = used_bytes + nb;
        end
      end
      OP_REMOVE: begin
        if (slot < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          used_bytes = used_bytes - tbl_size[slot];
          for (int i = slot; i + 1 < held; i++) begin
            tbl_key[i]  = tbl_key[i+1];
            tbl_data[i] = tbl_data[i+1];
            tbl_size[i] = tbl_size[i+1];
          end
          held--;
        end
      end
      OP_FIND: begin
        if (slot < 0) r.status = ST_NOT_FOUND;
        else r.found = tbl_data[slot];
      end
      default: begin
        held = 0;
        used_bytes = '0;
      end
    endcase
    r.count = CNT_OUT_W'(held);
    r.free_bytes = free_now();
    r.high_key = (held == 0) ? HIGHEST_EMPTY : $signed({1'b0, tbl_key[held-1]});
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  // Sender: present queued items, predict each one as it is taken
  always @(posedge clk) begin : item_driver
    request_t nxt;
    result_t  pred;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        pred = apply_request(op_t'(in_op), in_key, in_record_data, in_record_bytes);
        expected_results = {expected_results, pred};
      end
      if (!in_valid || !in_stall) begin
        if (send_wait != 0) begin
          in_valid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pending_requests.size() != 0) begin
          nxt = pending_requests.pop_front();
          in_op <= nxt.op;
          in_key <= nxt.key;
          in_record_data <= nxt.data;
          in_record_bytes <= nxt.rec_bytes;
          in_valid <= 1'b1;
          send_wait <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result item against the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    int unsigned nw;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rcv_wait <= 0;
    end else begin
      nw = (rcv_wait != 0) ? rcv_wait - 1 : 0;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", out_status, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_found_data !== want.found)
            report_mismatch("found_data", out_found_data, want.found);
          if (out_record_count !== want.count)
            report_mismatch("record_count", out_record_count, want.count);
          if (out_free_bytes !== want.free_bytes)
            report_mismatch("free_bytes", out_free_bytes, want.free_bytes);
          if (out_highest_key !== want.high_key)
            report_mismatch("highest_key", out_highest_key, want.high_key);
        end
        nw = draw_gap();
      end
      rcv_wait <= nw;
      out_stall <= (nw != 0) || (long_hold != 0);
    end
  end

  always @(posedge clk) begin
    if (long_hold != 0) long_hold <= long_hold - 1;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add(input op_t op, input int k, input logic [DATA_W-1:0] d,
                     input int nb);
    request_t r;
    r.op = op;
    r.key = KEY_W'(k);
    r.data = d;
    r.rec_bytes = SIZE_W'(nb);
    pending_requests = {pending_requests, r};
    requests_queued++;
  endtask

  task automatic queue_random(input int n, input int key_base, input int key_span,
                              input int size_cap, input int ins_pct);
    op_t op;
    int pick;
    int k;
    int nb;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < ins_pct) op = OP_INSERT;
      else if (pick < ins_pct + (99 - ins_pct) / 3) op = OP_REMOVE;
      else if (pick < 99) op = OP_FIND;
      else op = OP_CLEAR;
      if ($urandom_range(0, 19) == 0) k = $urandom_range(0, 131071);
      else k = key_base + $urandom_range(0, key_span - 1);
      if ($urandom_range(0, 9) == 0) nb = $urandom_range(0, 1023);
      else nb = $urandom_range(0, size_cap);
      add(op, k, {$urandom, $urandom}, nb);
    end
  endtask

  task automatic wait_drained();
    while (results_seen != requests_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_block_size(input logic [CFG_DW-1:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_BLOCK_SIZE;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    blk_size = value[BS_W-1:0];
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[BS_W-1:0] !== blk_size)
      report_mismatch("block_size readback", cfg_prdata, blk_size);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    add(OP_FIND,   0,      '0, 0);
    add(OP_REMOVE, 0,      '0, 0);
    add(OP_INSERT, 0,      '0, 0);
    add(OP_INSERT, 131071, '1, 1);
    add(OP_INSERT, 99999,  64'h0123_4567_89ab_cdef, 1023);
    add(OP_INSERT, 50000,  64'hfedc_ba98_7654_3210, 497);
    add(OP_INSERT, 50000,  64'h1111_2222_3333_4444, 2);
    add(OP_INSERT, 7,      64'h8000_0000_0000_0001, 2);
    add(OP_INSERT, 8,      64'h5555_5555_5555_5555, 1);
    add(OP_INSERT, 9,      64'haaaa_aaaa_aaaa_aaaa, 0);
    add(OP_FIND,   131071, '0, 0);
    add(OP_FIND,   50000,  '1, 1023);
    add(OP_FIND,   12345,  '0, 0);
    add(OP_REMOVE, 50000,  '0, 0);
    add(OP_REMOVE, 50000,  '0, 0);
    add(OP_INSERT, 65536,  64'ha5a5_a5a5_a5a5_a5a5, 300);
    add(OP_CLEAR,  99999,  '1, 1023);
    add(OP_FIND,   0,      '0, 0);
    add(OP_INSERT, 3,      64'h3, 5);
    add(OP_INSERT, 1,      64'h1, 5);
    add(OP_REMOVE, 3,      '0, 0);
    add(OP_FIND,   1,      '0, 0);
    add(OP_CLEAR,  0,      '0, 0);
    wait_drained();

    set_block_size(32'd4096);
    queue_random(400, 0, 100, 40, 60);
    long_hold <= 400;
    wait_drained();

    set_block_size(32'd12);
    queue_random(60, 0, 100, 2, 40);
    wait_drained();

    set_block_size(32'hffff_ffff);
    no_idle <= 1'b1;
    queue_random(200, 0, 131072, 1023, 50);
    wait_drained();
    no_idle <= 1'b0;
    queue_random(200, 65500, 64, 200, 50);
    wait_drained();

    set_block_size(32'd0);
    queue_random(40, 0, 32, 3, 50);
    wait_drained();

    set_block_size(32'd512);
    queue_random(200, 0, 200, 60, 55);
    wait_drained();
    queue_random(200, 0, 200, 60, 45);
    wait_drained();

    set_block_size(32'd100);
    queue_random(200, 0, 64, 30, 50);
    wait_drained();

    set_block_size(32'd2048);
    queue_random(250, 99900, 300, 80, 55);
    wait_drained();
    repeat (8) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), 0);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/skrb_pkg.sv
hw/rtl/skrb_cell.sv
hw/rtl/sorted_keyed_record_block.sv
tb/sv/tb_sorted_keyed_record_block.sv
